/* sv/grid_strip_fill_engine_assert.svh */
// ---------------------------------------------------------------------------
// grid_strip_fill_engine_assert.svh
// Assertion macros shared by the strip fill engine.
// ---------------------------------------------------------------------------
`ifndef GRID_STRIP_FILL_ENGINE_ASSERT_SVH
`define GRID_STRIP_FILL_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define GSFE_ASSERT_HOLDS(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsfe: same-cycle check failed");

// Next-cycle implication, off while reset is high
`define GSFE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsfe: next-cycle check failed");

`endif

/* sv/gsfe_pkg.sv */
// ---------------------------------------------------------------------------
// gsfe_pkg
// Types, constants and microcode program of the grid strip fill engine.
// ---------------------------------------------------------------------------
package gsfe_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int VALUE_BITS = 8;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS  = $clog2(CELL_COUNT);
  localparam int TOTAL_BITS = ADDR_BITS + 1;
  localparam int DIM_BITS   = 7;

  // Command field widths
  localparam int KIND_BITS  = 2;
  localparam int SIDX_BITS  = 12;
  localparam int LEN_BITS   = 12;
  localparam int COUNT_BITS = 7;
  localparam int FILL_BITS  = 8;
  localparam int RIDX_BITS  = 12;

  // Linear positions: line start times width plus strip length times width
  localparam int START_BITS = SIDX_BITS + DIM_BITS - 1;
  localparam int POS_BITS   = START_BITS + 2;

  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [START_BITS-1:0] start_t;
  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [VALUE_BITS-1:0] cell_t;

  // Command codes
  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic [KIND_BITS-1:0] KIND_LINE = 2'd1;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;
  localparam dim_t DIM_RESET = 7'd32;

  // Remainder unit: one dividend bit per step
  localparam logic [3:0] REM_LAST = 4'(SIDX_BITS - 1);
  localparam addr_t ADDR_LAST = addr_t'(CELL_COUNT - 1);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP, OP_SETUP, OP_REM, OP_ENDPT, OP_STRIP,
    OP_CELL, OP_NEXT, OP_EMIT, OP_READ, OP_CLEAR
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER, COND_NO_CMD, COND_IS_READ, COND_REM_MORE,
    COND_STRIPS_DONE, COND_CELL_MORE, COND_OUT_BUSY, COND_CLR_MORE
  } cond_t;

  // Program addresses
  typedef logic [3:0] pc_t;
  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_SETUP = 4'd1;
  localparam pc_t PC_REM   = 4'd2;
  localparam pc_t PC_ENDPT = 4'd3;
  localparam pc_t PC_STRIP = 4'd4;
  localparam pc_t PC_CELL  = 4'd5;
  localparam pc_t PC_NEXT  = 4'd6;
  localparam pc_t PC_EMIT  = 4'd7;
  localparam pc_t PC_READ  = 4'd8;
  localparam pc_t PC_CLEAR = 4'd9;

  // One control word: operation, jump taken when cond holds, else next_pc
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   jump_pc;
    pc_t   next_pc;
  } uword_t;

  // Microcode ROM
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:  w = '{OP_NOP,   COND_NO_CMD,      PC_IDLE,  PC_SETUP};
      PC_SETUP: w = '{OP_SETUP, COND_IS_READ,     PC_READ,  PC_REM};
      PC_REM:   w = '{OP_REM,   COND_REM_MORE,    PC_REM,   PC_ENDPT};
      PC_ENDPT: w = '{OP_ENDPT, COND_NEVER,       PC_ENDPT, PC_STRIP};
      PC_STRIP: w = '{OP_STRIP, COND_STRIPS_DONE, PC_EMIT,  PC_CELL};
      PC_CELL:  w = '{OP_CELL,  COND_CELL_MORE,   PC_CELL,  PC_NEXT};
      PC_NEXT:  w = '{OP_NEXT,  COND_NEVER,       PC_NEXT,  PC_STRIP};
      PC_EMIT:  w = '{OP_EMIT,  COND_OUT_BUSY,    PC_EMIT,  PC_IDLE};
      PC_READ:  w = '{OP_READ,  COND_NEVER,       PC_READ,  PC_EMIT};
      PC_CLEAR: w = '{OP_CLEAR, COND_CLR_MORE,    PC_CLEAR, PC_IDLE};
      default:  w = '{OP_NOP,   COND_NEVER,       PC_IDLE,  PC_IDLE};
    endcase
    return w;
  endfunction

  // Saturate a grid dimension to 1..lim
  function automatic dim_t clamp_dim(dim_t v, dim_t lim);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/gsfe_cmd_if.sv */
// ---------------------------------------------------------------------------
// gsfe_cmd_if
// Command channel of the strip fill engine: valid/ready plus command fields.
// ---------------------------------------------------------------------------
interface gsfe_cmd_if import gsfe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [KIND_BITS-1:0]  start_kind;
  logic [SIDX_BITS-1:0]  start_index;
  logic                  vertical;
  logic                  to_end;
  logic                  to_map_end;
  logic [LEN_BITS-1:0]   strip_length;
  logic [COUNT_BITS-1:0] strip_count;
  logic [FILL_BITS-1:0]  fill_value;
  logic [RIDX_BITS-1:0]  read_index;

  modport source (
    output valid, func, start_kind, start_index, vertical, to_end, to_map_end,
           strip_length, strip_count, fill_value, read_index,
    input  ready
  );

  modport sink (
    input  valid, func, start_kind, start_index, vertical, to_end, to_map_end,
           strip_length, strip_count, fill_value, read_index,
    output ready
  );
endinterface

/* sv/gsfe_rsp_if.sv */
// ---------------------------------------------------------------------------
// gsfe_rsp_if
// Result channel of the strip fill engine: valid/ready plus result fields.
// ---------------------------------------------------------------------------
interface gsfe_rsp_if import gsfe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FILL_BITS-1:0] read_value;
  logic                 out_of_range;

  modport source (
    output valid, read_value, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, read_value, out_of_range,
    output ready
  );
endinterface

/* sv/grid_strip_fill_engine.sv */
// ---------------------------------------------------------------------------
// grid_strip_fill_engine
// Cell grid with strip fills and single-cell reads, run by a microcode
// sequencer over a cell memory with one write port and one read port.
// ---------------------------------------------------------------------------
// Usage:
//   cmd  : one beat per command (fill strips or read one cell).
//   rsp  : one beat per command: read_value and out_of_range.
//   cfg_*: grid_width (index 0) and grid_height (index 1), written only
//          while no command is in flight; values saturate to 1..64.
// Reset: after rst drops, a clearing pass zeroes all 4096 cells, one per
//   cycle; cmd.ready stays low until the pass is over.
// Sequence per command:
//   read : the cell is fetched through the registered read port.
//   fill : a 12-step remainder unit runs first; then the memory write port
//          paints one cell per cycle, strip by strip.
// One command is in work at a time. A finished result waits in an output
//   register; the next command is accepted meanwhile, and its own result
//   waits for that register while rsp.ready is low.
// ---------------------------------------------------------------------------
`include "grid_strip_fill_engine_assert.svh"

module grid_strip_fill_engine import gsfe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]       cfg_data,
  gsfe_cmd_if.sink                  cmd,
  gsfe_rsp_if.source                rsp
);

  // Sequencer
  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;
  logic   take_jump;

  // Configuration
  dim_t w;
  dim_t h;

  // Latched command
  logic                  c_func;
  logic [KIND_BITS-1:0]  c_kind;
  logic [SIDX_BITS-1:0]  c_sidx;
  logic                  c_vert;
  logic                  c_to_end;
  logic                  c_to_map;
  logic [LEN_BITS-1:0]   c_len;
  logic [COUNT_BITS-1:0] c_count;
  cell_t                 c_val;
  logic [RIDX_BITS-1:0]  c_ridx;

  // Datapath registers
  total_t                total;
  start_t                start;
  pos_t                  e0;
  pos_t                  j;
  pos_t                  e;
  logic [COUNT_BITS-1:0] i;
  dim_t                  rem;
  logic [3:0]            bitcnt;
  addr_t                 clr_addr;
  logic                  flag;
  cell_t                 rval;

  // Memory
  cell_t mem [CELL_COUNT];
  cell_t mem_q;
  logic  mem_we;
  addr_t mem_waddr;
  cell_t mem_wdata;

  // Result register
  logic  rsp_valid;
  cell_t rsp_value;
  logic  rsp_oor;

  // Combinational helpers
  logic   cmd_fire;
  logic   cell_cont;
  logic   cell_oob;
  logic   cell_write;
  logic   rd_in_range;
  dim_t   rem_shift;
  dim_t   col;
  pos_t   tot_m1;
  pos_t   end_pt;
  pos_t   strip_off;
  pos_t   step;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (pc == PC_IDLE);
  assign uw        = ucode_rom(pc);

  // Cell loop tests: within the strip, and inside the grid
  assign step       = c_vert ? pos_t'(w) : pos_t'(1);
  assign cell_cont  = c_to_end ? (j <= e) : (j < e);
  assign cell_oob   = (j >= pos_t'(total));
  assign cell_write = cell_cont && !cell_oob;
  assign rd_in_range = (total_t'(c_ridx) < total);

  // One restoring remainder step on the start index
  assign rem_shift = {rem[DIM_BITS-2:0], c_sidx[REM_LAST - bitcnt]};

  // Strip end point of strip zero
  assign col    = (c_kind == KIND_LINE) ? '0 : rem;
  assign tot_m1 = pos_t'(total) - pos_t'(1);
  always_comb begin
    if (!c_to_end) begin
      end_pt = pos_t'(start) + (c_vert ? pos_t'(c_len) * pos_t'(w) : pos_t'(c_len));
    end else if (c_to_map) begin
      end_pt = tot_m1;
    end else if (!c_vert) begin
      end_pt = pos_t'(start) + pos_t'(w - dim_t'(1) - col);
    end else if (pos_t'(start) > tot_m1) begin
      end_pt = pos_t'(start);
    end else begin
      // bottom cell of the start column: last row, same column
      end_pt = tot_m1 - pos_t'(w - dim_t'(1) - col);
    end
  end

  // Offset of strip i: one column (vertical) or one row (horizontal)
  assign strip_off = c_vert ? pos_t'(i) : pos_t'(i) * pos_t'(w);

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:       take_jump = 1'b0;
      COND_NO_CMD:      take_jump = !cmd_fire;
      COND_IS_READ:     take_jump = (c_func == FUNC_READ);
      COND_REM_MORE:    take_jump = (bitcnt != REM_LAST);
      COND_STRIPS_DONE: take_jump = (i == c_count);
      COND_CELL_MORE:   take_jump = cell_write;
      COND_OUT_BUSY:    take_jump = rsp_valid && !rsp.ready;
      COND_CLR_MORE:    take_jump = (clr_addr != ADDR_LAST);
    endcase
  end

  assign pc_next = take_jump ? uw.jump_pc : uw.next_pc;

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      w         <= DIM_RESET;
      h         <= DIM_RESET;
    end else begin
      pc <= pc_next;
      if (uw.op == OP_CLEAR) begin
        clr_addr <= clr_addr + addr_t'(1);
      end
      if (uw.op == OP_EMIT && !(rsp_valid && !rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  w <= clamp_dim(cfg_data, dim_t'(MAX_WIDTH));
          REG_GRID_HEIGHT: h <= clamp_dim(cfg_data, dim_t'(MAX_HEIGHT));
        endcase
      end
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      c_func   <= cmd.func;
      c_kind   <= cmd.start_kind;
      c_sidx   <= cmd.start_index;
      c_vert   <= cmd.vertical;
      c_to_end <= cmd.to_end;
      c_to_map <= cmd.to_map_end;
      c_len    <= cmd.strip_length;
      c_count  <= cmd.strip_count;
      c_val    <= cell_t'(cmd.fill_value);
      c_ridx   <= cmd.read_index;
    end
  end

  // Datapath, driven by the control word
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_SETUP: begin
        total  <= total_t'(w) * total_t'(h);
        start  <= (c_kind == KIND_LINE) ? start_t'(w) * start_t'(c_sidx)
                                        : start_t'(c_sidx);
        rem    <= '0;
        bitcnt <= '0;
        i      <= '0;
        flag   <= 1'b0;
        rval   <= '0;
      end
      OP_REM: begin
        rem    <= (rem_shift >= w) ? rem_shift - w : rem_shift;
        bitcnt <= bitcnt + 4'd1;
      end
      OP_ENDPT: begin
        e0 <= end_pt;
      end
      OP_STRIP: begin
        j <= pos_t'(start) + strip_off;
        e <= e0 + strip_off;
      end
      OP_CELL: begin
        if (cell_write) begin
          j <= j + step;
        end else if (cell_cont) begin
          flag <= 1'b1;
        end
      end
      OP_NEXT: begin
        i <= i + COUNT_BITS'(1);
      end
      OP_READ: begin
        rval <= rd_in_range ? mem_q : '0;
        flag <= !rd_in_range;
      end
      OP_EMIT: begin
        if (!(rsp_valid && !rsp.ready)) begin
          rsp_value <= rval;
          rsp_oor   <= flag;
        end
      end
      default: begin
      end
    endcase
  end

  // Cell memory: one write port, one registered read port
  assign mem_we    = (uw.op == OP_CLEAR) || (uw.op == OP_CELL && cell_write);
  assign mem_waddr = (uw.op == OP_CLEAR) ? clr_addr : j[ADDR_BITS-1:0];
  assign mem_wdata = (uw.op == OP_CLEAR) ? '0 : c_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[c_ridx[ADDR_BITS-1:0]];
  end

  // Result channel
  assign rsp.valid        = rsp_valid;
  assign rsp.read_value   = rsp_value;
  assign rsp.out_of_range = rsp_oor;

  // Checks
  `GSFE_ASSERT_NEXT(a_accept_setup, clk, rst, cmd_fire, pc == PC_SETUP)
  `GSFE_ASSERT_HOLDS(a_clear_blocks, clk, rst, pc == PC_CLEAR, !cmd.ready)
  `GSFE_ASSERT_HOLDS(a_write_in_grid, clk, rst, mem_we && pc == PC_CELL, j < pos_t'(total))
  `GSFE_ASSERT_NEXT(a_emit_only, clk, rst, pc != PC_EMIT && !rsp_valid, !rsp_valid)
  `GSFE_ASSERT_HOLDS(a_rem_below_w, clk, rst, pc == PC_ENDPT, rem < w)

endmodule

/* verif/grid_strip_fill_engine_tb.sv */
// ---------------------------------------------------------------------------
// grid_strip_fill_engine_tb
// Self-checking bench for the strip fill engine. A driver feeds fill and read
// commands from a queue and a monitor checks every reply. The expected
// replies come from a cycle-free grid model updated on each accepted command.
// The bench steps through several grid sizes, idles and stalls both channels
// at random, and holds the reply side off for long stretches.
// ---------------------------------------------------------------------------
module grid_strip_fill_engine_tb import gsfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Start kinds without a package name
  localparam logic [KIND_BITS-1:0] KIND_COLUMN = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_TILE   = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_SPARE  = 2'd3;

  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_SPACING  = 400;
  localparam int PHASE_ITEMS   = 115;
  localparam int PHASE_COUNT   = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 40;
  localparam int PRINT_CAP     = 200;

  typedef struct packed {
    logic                  func;
    logic [KIND_BITS-1:0]  kind;
    logic [SIDX_BITS-1:0]  sidx;
    logic                  vert;
    logic                  to_end;
    logic                  to_map;
    logic [LEN_BITS-1:0]   len;
    logic [COUNT_BITS-1:0] count;
    logic [FILL_BITS-1:0]  value;
    logic [RIDX_BITS-1:0]  ridx;
  } grid_cmd_t;

  typedef struct packed {
    logic [FILL_BITS-1:0] value;
    logic                 oor;
  } grid_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  dim_t cfg_data;

  gsfe_cmd_if cmd_ch ();
  gsfe_rsp_if rsp_ch ();

  grid_strip_fill_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // Grid model and its registers
  cell_t       grid_cells [CELL_COUNT];
  dim_t        width_reg;
  dim_t        height_reg;
  grid_reply_t reply_q [$];
  grid_cmd_t   cmd_q [$];
  grid_cmd_t   offered;
  grid_reply_t reply_want;

  int   queued;
  int   accepted;
  int   mismatches;
  int   rsp_beats;
  int   hold_mark;
  int   hold_left;
  int   stall_left;
  int   gap_left;
  int   cycle_count;
  logic idle_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned sat_dim(dim_t v, int unsigned lim);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    else if (r > lim) r = lim;
    return r;
  endfunction

  // Apply one command to the grid and queue the reply it produces
  function automatic void run_grid_command(grid_cmd_t c);
    int unsigned w, total, start, step, shift, stop, j, e;
    logic        incl;
    grid_reply_t r;
    w     = sat_dim(width_reg, MAX_WIDTH);
    total = w * sat_dim(height_reg, MAX_HEIGHT);
    r     = '0;
    if (c.func == FUNC_READ) begin
      if (c.ridx < total) r.value = grid_cells[c.ridx];
      else r.oor = 1'b1;
    end else begin
      start = (c.kind == KIND_LINE) ? w * c.sidx : c.sidx;
      step  = c.vert ? w : 1;
      shift = c.vert ? 1 : w;
      incl  = c.to_end;
      if (!c.to_end) stop = start + c.len * step;
      else if (c.to_map) stop = total - 1;
      else if (!c.vert) stop = start + (w - 1 - (start % w));
      else if (start > total - 1) stop = start;
      else stop = start + ((total - 1 - start) / w) * w;
      for (int i = 0; i < c.count; i++) begin
        j = start + shift * i;
        e = stop + shift * i;
        while (incl ? (j <= e) : (j < e)) begin
          if (j >= total) begin
            r.oor = 1'b1;
            break;
          end
          grid_cells[j] = c.value;
          j += step;
        end
      end
    end
    reply_q.push_back(r);
  endfunction

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on reply %0d, %s: got %0d, want %0d",
               $realtime, rsp_beats, what, got, want);
    mismatches++;
  endtask

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic grid_cmd_t mk_fill(logic [KIND_BITS-1:0] kind, int sidx, logic vert,
                                        logic to_end, logic to_map, int len, int count,
                                        logic [FILL_BITS-1:0] value);
    grid_cmd_t c;
    c        = '0;
    c.func   = FUNC_FILL;
    c.kind   = kind;
    c.sidx   = SIDX_BITS'(sidx);
    c.vert   = vert;
    c.to_end = to_end;
    c.to_map = to_map;
    c.len    = LEN_BITS'(len);
    c.count  = COUNT_BITS'(count);
    c.value  = value;
    return c;
  endfunction

  function automatic grid_cmd_t mk_read(int ridx);
    grid_cmd_t c;
    c      = '0;
    c.func = FUNC_READ;
    c.ridx = RIDX_BITS'(ridx);
    return c;
  endfunction

  // Random command sized so that most fills stay short
  function automatic grid_cmd_t random_cmd();
    grid_cmd_t   c;
    int unsigned w, h, total, pick, top;
    w        = sat_dim(width_reg, MAX_WIDTH);
    h        = sat_dim(height_reg, MAX_HEIGHT);
    total    = w * h;
    c.func   = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_FILL;
    c.kind   = KIND_BITS'($urandom_range(0, 3));
    c.vert   = 1'($urandom_range(0, 1));
    c.to_end = ($urandom_range(0, 3) == 0);
    c.to_map = 1'($urandom_range(0, 1));
    c.value  = FILL_BITS'($urandom);
    // reads land mostly inside the grid, a few just past it or anywhere
    top = total + total / 8;
    if (top > 4095) top = 4095;
    if ($urandom_range(0, 7) == 0) c.ridx = RIDX_BITS'($urandom_range(0, 4095));
    else c.ridx = RIDX_BITS'($urandom_range(0, top));
    if ($urandom_range(0, 4) == 0) c.sidx = SIDX_BITS'($urandom_range(0, 4095));
    else if (c.kind == KIND_LINE) c.sidx = SIDX_BITS'($urandom_range(0, h - 1));
    else c.sidx = SIDX_BITS'($urandom_range(0, total - 1));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      c.count = COUNT_BITS'($urandom_range(0, 4));
      c.len   = LEN_BITS'($urandom_range(0, 24));
    end else if (pick < 92) begin
      c.count = COUNT_BITS'($urandom_range(5, 20));
      c.len   = LEN_BITS'($urandom_range(0, 8));
    end else if (pick < 96) begin
      c.count = COUNT_BITS'($urandom_range(21, 127));
      c.len   = LEN_BITS'($urandom_range(0, 3));
    end else begin
      c.count = COUNT_BITS'($urandom_range(1, 2));
      c.len   = LEN_BITS'($urandom_range(0, 4095));
    end
    // a horizontal map-end strip covers the rest of the map: keep few strips
    if (c.to_end && c.to_map && !c.vert) c.count = COUNT_BITS'($urandom_range(0, 2));
    return c;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, dim_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_reg = data;
    else height_reg = data;
  endtask

  task automatic send(grid_cmd_t c);
    cmd_q.push_back(c);
    queued++;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || accepted != queued || reply_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Command driver: offer queued commands, model each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else if (!(cmd_ch.valid && !cmd_ch.ready)) begin
      if (cmd_ch.valid) begin
        run_grid_command(offered);
        accepted++;
      end
      if (gap_left != 0) begin
        cmd_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        offered = cmd_q.pop_front();
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= offered.func;
        cmd_ch.start_kind   <= offered.kind;
        cmd_ch.start_index  <= offered.sidx;
        cmd_ch.vertical     <= offered.vert;
        cmd_ch.to_end       <= offered.to_end;
        cmd_ch.to_map_end   <= offered.to_map;
        cmd_ch.strip_length <= offered.len;
        cmd_ch.strip_count  <= offered.count;
        cmd_ch.fill_value   <= offered.value;
        cmd_ch.read_index   <= offered.ridx;
        gap_left            <= idle_on ? pick_gap() : 0;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Reply monitor: check each beat, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 0;
      stall_left   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_beats <= rsp_beats + 1;
        if (reply_q.size() == 0) begin
          note_mismatch("reply with no command pending", rsp_ch.read_value, 0);
        end else begin
          reply_want = reply_q.pop_front();
          if (rsp_ch.read_value !== reply_want.value)
            note_mismatch("read_value", rsp_ch.read_value, reply_want.value);
          if (rsp_ch.out_of_range !== reply_want.oor)
            note_mismatch("out_of_range", rsp_ch.out_of_range, reply_want.oor);
        end
      end
      // long hold-offs let the engine fill up and push back on commands
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (rsp_beats >= hold_mark) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_mark    <= hold_mark + HOLD_SPACING;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= pick_gap();
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, reply_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    dim_t new_w, new_h;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.func         = FUNC_FILL;
    cmd_ch.start_kind   = '0;
    cmd_ch.start_index  = '0;
    cmd_ch.vertical     = 1'b0;
    cmd_ch.to_end       = 1'b0;
    cmd_ch.to_map_end   = 1'b0;
    cmd_ch.strip_length = '0;
    cmd_ch.strip_count  = '0;
    cmd_ch.fill_value   = '0;
    cmd_ch.read_index   = '0;
    rsp_ch.ready        = 1'b0;
    width_reg           = DIM_RESET;
    height_reg          = DIM_RESET;
    queued              = 0;
    accepted            = 0;
    mismatches          = 0;
    rsp_beats           = 0;
    hold_mark           = 200;
    cycle_count         = 0;
    idle_on             = 1'b1;
    foreach (grid_cells[k]) grid_cells[k] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // clearing pass keeps commands out; wait until the engine takes them
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);

    // Directed commands on the reset-size 32 x 32 grid
    send(mk_read(0));
    send(mk_fill(KIND_COLUMN, 3, 0, 0, 0, 5, 1, 8'hFF));
    send(mk_read(5));
    send(mk_fill(KIND_LINE, 2, 1, 0, 0, 4, 3, 8'h5A));
    send(mk_fill(KIND_TILE, 40, 0, 1, 0, 0, 2, 8'h11));     // to row end
    send(mk_fill(KIND_TILE, 100, 1, 1, 0, 0, 2, 8'h22));    // to column end
    send(mk_fill(KIND_TILE, 1000, 0, 1, 1, 0, 2, 8'h33));   // map end, runs off
    send(mk_fill(KIND_TILE, 1020, 1, 1, 1, 0, 4, 8'h44));
    send(mk_fill(KIND_TILE, 4095, 1, 1, 0, 0, 1, 8'h55));   // column end past map
    send(mk_fill(KIND_SPARE, 500, 0, 0, 0, 3, 1, 8'h66));   // unused kind
    send(mk_fill(KIND_TILE, 4000, 0, 0, 0, 10, 0, 8'h77));  // no strips
    send(mk_fill(KIND_TILE, 4000, 0, 0, 0, 0, 5, 8'h77));   // empty strips
    send(mk_fill(KIND_LINE, 31, 1, 0, 0, 3, 1, 8'h88));     // off the bottom
    send(mk_fill(KIND_COLUMN, 30, 0, 0, 1, 5, 1, 8'h99));   // wraps a row
    send(mk_fill(KIND_TILE, 0, 0, 0, 0, 4095, 1, 8'hAB));   // longest strip
    send(mk_fill(KIND_TILE, 0, 0, 0, 0, 1, 127, 8'h01));    // most strips
    send(mk_fill(KIND_COLUMN, 0, 1, 1, 0, 0, 64, 8'h00));
    send(mk_fill(KIND_LINE, 4095, 0, 1, 0, 0, 1, 8'hCD));   // line far out
    send(mk_read(40));
    send(mk_read(100));
    send(mk_read(31));
    send(mk_read(1023));
    send(mk_read(1024));
    send(mk_read(4095));
    drain();

    // Random phases over a range of grid sizes, saturating values included
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       begin new_w = 7'd64;  new_h = 7'd64;  end
        1:       begin new_w = 7'd1;   new_h = 7'd1;   end
        2:       begin new_w = 7'd0;   new_h = 7'd127; end
        3:       begin new_w = 7'd127; new_h = 7'd0;   end
        4:       begin new_w = 7'd7;   new_h = 7'd5;   end
        5:       begin
          new_w = DIM_BITS'($urandom_range(1, 64));
          new_h = DIM_BITS'($urandom_range(1, 64));
        end
        6:       begin
          new_w = DIM_BITS'($urandom_range(0, 127));
          new_h = DIM_BITS'($urandom_range(0, 127));
        end
        default: begin new_w = 7'd3;   new_h = 7'd64;  end
      endcase
      write_reg(REG_GRID_WIDTH, new_w);
      write_reg(REG_GRID_HEIGHT, new_h);
      idle_on = (p % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd());
      drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (reply_q.size() != 0)
      note_mismatch("replies never delivered", 0, reply_q.size());
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
